### hdl/swm_pkg.sv
package swm_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned WIN_RESET   = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // min/max pair carried along the reduction chain
  typedef struct packed {
    sample_t mn;
    sample_t mx;
  } ext_t;

  localparam ext_t EXT_IDENT = '{mn: 16'sh7fff, mx: 16'sh8000};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_HOLD
  } state_e;

endpackage

### hdl/swm_cell.sv
module swm_cell import swm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned SUM_W = SAMPLE_W + $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic                    flush_i,
  input  logic [CNT_W-1:0]        size_i,
  input  sample_t                 sample_i,
  input  logic                    valid_i,
  output sample_t                 sample_o,
  output logic                    valid_o,
  input  ext_t                    ext_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output ext_t                    ext_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  sample_t                 smp_q;
  logic                    vld_q;
  ext_t                    ext_q, ext_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  // sample slot: shifts toward the tail, valid only inside the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (flush_i) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= valid_i && (IdxC < size_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      smp_q <= sample_i;
    end
  end

  // reduction wave travels from the tail toward cell 0
  always_comb begin
    ext_d = ext_i;
    sum_d = sum_i;
    if (vld_q) begin
      if (smp_q < ext_i.mn) ext_d.mn = smp_q;
      if (smp_q > ext_i.mx) ext_d.mx = smp_q;
      sum_d = sum_i + SUM_W'(smp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ext_q <= EXT_IDENT;
      sum_q <= '0;
    end else begin
      ext_q <= ext_d;
      sum_q <= sum_d;
    end
  end

  assign sample_o = smp_q;
  assign valid_o  = vld_q;
  assign ext_o    = ext_q;
  assign sum_o    = sum_q;

endmodule

### hdl/swm_div.sv
module swm_div import swm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned SUM_W = SAMPLE_W + $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    done_o,
  output sample_t                 quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic              neg_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W:0]    trial;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  res;

  assign mag   = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign trial = {rem_q, quo_q[SUM_W-1]};

  // restoring divide on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      rem_q <= '0;
      quo_q <= mag;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= CNT_W'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign res        = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = res[SAMPLE_W-1:0];
  assign done_o     = done_q;

endmodule

### hdl/sliding_window_mean_min_max_top.sv
// Each accepted sample shifts into cell 0; the reduction wave then crosses H cells, where H is
// the count of samples held after the new one (1..window), and a bit-serial divide of the
// SUM_W-bit sum (SUM_W = 16 + log2(DEPTH)) by H gives the mean, loaded into the result register.
// A new sample is taken only once the previous result has been loaded into that register.
// Reset (async, active low): window empty, window size 64 (capped at DEPTH), no
// result pending. Writing window_size also empties the window.
module sliding_window_mean_min_max_top import swm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    window_size_i,
  // sample channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  sample_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  average_o,
  output logic signed [15:0]  minimum_o,
  output logic signed [15:0]  maximum_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(DEPTH);
  localparam logic [CNT_W-1:0] SizeReset =
    CNT_W'((WIN_RESET < DEPTH) ? WIN_RESET : DEPTH);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [CNT_W-1:0] size_q, size_d;    // effective window size, 1..DEPTH
  logic [CNT_W-1:0] held_q, held_d;    // samples currently in the window
  logic [CNT_W-1:0] cnt_q, cnt_d;      // reduction wave cycles still to go
  logic             ovld_q, ovld_d;
  sample_t          avg_q, min_q, max_q;
  logic             out_load;

  logic             shift;
  logic             div_start;
  logic             div_done;
  sample_t          div_quo;

  // ---------------------------------------------------------------------------
  // Cell chain: samples move from cell 0 toward the tail on each transaction,
  // min/max/sum flow from the tail back to cell 0, one cell per cycle.
  // ---------------------------------------------------------------------------
  sample_t                 smp_w [DEPTH];
  logic                    vld_w [DEPTH];
  ext_t                    ext_w [DEPTH];
  logic signed [SUM_W-1:0] sum_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t                 smp_in;
    logic                    vld_in;
    ext_t                    ext_in;
    logic signed [SUM_W-1:0] sum_in;

    if (i == 0) begin : g_head
      assign smp_in = sample_i;
      assign vld_in = 1'b1;
    end else begin : g_body
      assign smp_in = smp_w[i-1];
      assign vld_in = vld_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign ext_in = EXT_IDENT;
      assign sum_in = '0;
    end else begin : g_link
      assign ext_in = ext_w[i+1];
      assign sum_in = sum_w[i+1];
    end

    swm_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .flush_i  (cfg_we_i),
      .size_i   (size_q),
      .sample_i (smp_in),
      .valid_i  (vld_in),
      .sample_o (smp_w[i]),
      .valid_o  (vld_w[i]),
      .ext_i    (ext_in),
      .sum_i    (sum_in),
      .ext_o    (ext_w[i]),
      .sum_o    (sum_w[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Mean: window sum over held count, truncated toward zero
  // ---------------------------------------------------------------------------
  swm_div #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_w[0]),
    .divisor_i  (held_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    ovld_d     = ovld_q && !out_ready_i;
    in_ready_o = 1'b0;
    shift      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // new sample enters cell 0; the oldest falls off past the window
          shift   = 1'b1;
          held_d  = (held_q < size_q) ? held_q + 1'b1 : held_q;
          cnt_d   = held_d;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          // cell 0 now sees the whole window
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!ovld_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!ovld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      ovld_d = 1'b1;
    end

    // size write empties the window; zero means one, capped at DEPTH
    if (cfg_we_i) begin
      held_d = '0;
      if (window_size_i == '0) begin
        size_d = CNT_W'(1);
      end else if (32'(window_size_i) > 32'(DEPTH)) begin
        size_d = CNT_W'(DEPTH);
      end else begin
        size_d = CNT_W'(window_size_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      held_q <= '0;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      size_q <= size_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  // result register: frees the datapath while a result waits downstream
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q <= div_quo;
      min_q <= ext_w[0].mn;
      max_q <= ext_w[0].mx;
    end
  end

  assign out_valid_o = ovld_q;
  assign average_o   = avg_q;
  assign minimum_o   = min_q;
  assign maximum_o   = max_q;

endmodule
